@@ src/mbps_pkg.sv @@
package mbps_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int POS_W             = $clog2(MAX_PATTERN_BYTES);
    localparam int PAT_WORDS         = MAX_PATTERN_BYTES / 8;
    localparam int ADDR_W            = 48;
    localparam int CNT_W             = 32;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 64;

    typedef logic [7:0]        t_byte;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_0_7   = 3'd0,
        CFG_PAT_8_15  = 3'd1,
        CFG_PAT_16_23 = 3'd2,
        CFG_PAT_24_31 = 3'd3,
        CFG_CMP_EN    = 3'd4,
        CFG_PAT_LEN   = 3'd5,
        CFG_IMG_BASE  = 3'd6
    } t_cfg_idx;

    // configuration as seen by the datapath; len is already clamped to 1..MAX
    typedef struct packed {
        logic [MAX_PATTERN_BYTES-1:0][7:0] pat;
        logic [MAX_PATTERN_BYTES-1:0]      cmp;
        logic [LEN_W-1:0]                  len;
        t_addr                             base;
    } t_cfg;

    // first pipeline stage contents
    typedef struct packed {
        logic valid;
        logic last;
        logic enough;
        t_cnt start;
    } t_stage;

endpackage

@@ src/mbps_if.sv @@
interface mbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] image_byte;
    logic       last_byte;

    modport source (output valid, output image_byte, output last_byte, input ready);
    modport sink   (input valid, input image_byte, input last_byte, output ready);
endinterface

interface mbps_out_if;
    logic        valid;
    logic        ready;
    logic        match_found;
    logic [47:0] match_address;

    modport source (output valid, output match_found, output match_address, input ready);
    modport sink   (input valid, input match_found, input match_address, output ready);
endinterface

interface mbps_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/mbps_cfg_regs.sv @@
module mbps_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mbps_cfg_if.sink           i_cfg_ch,
    output mbps_pkg::t_cfg     o_cfg
);

    logic [mbps_pkg::PAT_WORDS-1:0][63:0]   r_pat;
    logic [mbps_pkg::MAX_PATTERN_BYTES-1:0] r_cmp;
    logic [5:0]                             r_len;
    mbps_pkg::t_addr                        r_base;
    logic                                   w_wr;

    assign i_cfg_ch.ready = 1'b1;
    assign w_wr           = i_cfg_ch.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_cmp  <= '0;
            r_len  <= 6'd1;
            r_base <= '0;
        end else if (w_wr) begin
            case (i_cfg_ch.index)
                mbps_pkg::CFG_PAT_0_7:   r_pat[0] <= i_cfg_ch.data;
                mbps_pkg::CFG_PAT_8_15:  r_pat[1] <= i_cfg_ch.data;
                mbps_pkg::CFG_PAT_16_23: r_pat[2] <= i_cfg_ch.data;
                mbps_pkg::CFG_PAT_24_31: r_pat[3] <= i_cfg_ch.data;
                mbps_pkg::CFG_CMP_EN:    r_cmp    <= i_cfg_ch.data[31:0];
                mbps_pkg::CFG_PAT_LEN:   r_len    <= i_cfg_ch.data[5:0];
                mbps_pkg::CFG_IMG_BASE:  r_base   <= i_cfg_ch.data[47:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, anything above the window depth acts as full depth
    always_comb begin
        o_cfg.pat  = r_pat;
        o_cfg.cmp  = r_cmp;
        o_cfg.base = r_base;
        if (r_len == 6'd0) begin
            o_cfg.len = mbps_pkg::LEN_W'(1);
        end else if (r_len > 6'(mbps_pkg::MAX_PATTERN_BYTES)) begin
            o_cfg.len = mbps_pkg::LEN_W'(mbps_pkg::MAX_PATTERN_BYTES);
        end else begin
            o_cfg.len = mbps_pkg::LEN_W'(r_len);
        end
    end

endmodule

@@ src/mbps_window.sv @@
module mbps_window (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_accept,
    input  logic                                   i_advance,
    input  logic [7:0]                             i_byte,
    input  logic                                   i_last,
    input  logic [mbps_pkg::LEN_W-1:0]             i_len,
    output logic [mbps_pkg::MAX_PATTERN_BYTES-1:0][7:0] o_window,
    output mbps_pkg::t_stage                       o_stage
);

    logic [mbps_pkg::MAX_PATTERN_BYTES-1:0][7:0] r_window;
    mbps_pkg::t_cnt   r_seen;
    mbps_pkg::t_cnt   w_seen_inc;
    mbps_pkg::t_stage r_stage;

    // count saturates at all ones
    assign w_seen_inc = (r_seen == '1) ? r_seen : r_seen + 1'b1;

    // entry 0 is the newest byte; stale entries are never compared since
    // the byte count gates the compare
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_window <= {r_window[mbps_pkg::MAX_PATTERN_BYTES-2:0], i_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen        <= '0;
            r_stage.valid <= 1'b0;
        end else if (i_accept) begin
            r_seen         <= i_last ? '0 : w_seen_inc;
            r_stage.valid  <= 1'b1;
            r_stage.last   <= i_last;
            r_stage.enough <= (w_seen_inc >= mbps_pkg::CNT_W'(i_len));
            r_stage.start  <= w_seen_inc - mbps_pkg::CNT_W'(i_len);
        end else if (i_advance) begin
            r_stage.valid <= 1'b0;
        end
    end

    assign o_window = r_window;
    assign o_stage  = r_stage;

endmodule

@@ src/mbps_match.sv @@
module mbps_match (
    input  logic [mbps_pkg::MAX_PATTERN_BYTES-1:0][7:0] i_window,
    input  mbps_pkg::t_cfg                              i_cfg,
    output logic                                        o_hit
);

    logic [mbps_pkg::MAX_PATTERN_BYTES-1:0] w_ok;

    // window slot i holds pattern byte len-1-i; slots at or past len are free
    for (genvar gi = 0; gi < mbps_pkg::MAX_PATTERN_BYTES; gi++) begin : g_slot
        logic [mbps_pkg::LEN_W-1:0] w_pos;
        logic [mbps_pkg::POS_W-1:0] w_j;

        assign w_pos   = i_cfg.len - mbps_pkg::LEN_W'(gi) - mbps_pkg::LEN_W'(1);
        assign w_j     = w_pos[mbps_pkg::POS_W-1:0];
        assign w_ok[gi] = (mbps_pkg::LEN_W'(gi) >= i_cfg.len) || !i_cfg.cmp[w_j]
                          || (i_cfg.pat[w_j] == i_window[gi]);
    end

    assign o_hit = &w_ok;

endmodule

@@ src/masked_byte_pattern_search_core.sv @@
// Channel   Dir  Payload                                Accepted when
// -------   ---  -------------------------------------  ----------------------
// i_in_ch   in   image_byte[7:0], last_byte             valid && ready
// o_out_ch  out  match_found, match_address[47:0]       valid && ready
// i_cfg_ch  in   index[2:0], data[63:0]                 valid && ready (always)
//
// One byte per cycle sustained while the output is not backed up. Each item is
// registered in the window stage, and its result (if any) then moves into the
// output register, which drives o_out_ch.valid. A backed-up output stalls the
// window stage, and input ready drops only while both stages hold items.
// Synchronous active-low reset clears pattern registers (length to 1), byte
// count, match flag and valid bits; no clearing pass.
module masked_byte_pattern_search_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mbps_in_if.sink    i_in_ch,
    mbps_out_if.source o_out_ch,
    mbps_cfg_if.sink   i_cfg_ch
);

    mbps_pkg::t_cfg   w_cfg;
    mbps_pkg::t_stage w_stage;
    logic [mbps_pkg::MAX_PATTERN_BYTES-1:0][7:0] w_window;

    logic            w_accept;
    logic            w_advance;
    logic            w_hit;
    logic            w_found;
    logic            w_missed;

    logic            r_reported;
    logic            r_out_valid;
    logic            r_out_found;
    mbps_pkg::t_addr r_out_addr;

    // configuration register file
    mbps_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_ch (i_cfg_ch),
        .o_cfg    (w_cfg)
    );

    // first stage: sliding window, byte count, start offset
    mbps_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_advance (w_advance),
        .i_byte    (i_in_ch.image_byte),
        .i_last    (i_in_ch.last_byte),
        .i_len     (w_cfg.len),
        .o_window  (w_window),
        .o_stage   (w_stage)
    );

    // masked compare of the whole window against the pattern
    mbps_match u_match (
        .i_window (w_window),
        .i_cfg    (w_cfg),
        .o_hit    (w_hit)
    );

    // window stage moves on when the output register is free or being emptied
    assign w_advance      = w_stage.valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready  = !w_stage.valid || w_advance;
    assign w_accept       = i_in_ch.valid && i_in_ch.ready;

    // first match of the scan wins; not-found only on the last byte
    assign w_found  = !r_reported && w_stage.enough && w_hit;
    assign w_missed = !r_reported && !w_found && w_stage.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reported  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_reported  <= w_stage.last ? 1'b0 : (r_reported || w_found);
            r_out_valid <= w_found || w_missed;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_found <= w_found;
            r_out_addr  <= w_found
                ? w_cfg.base + mbps_pkg::ADDR_W'(w_stage.start)
                : '0;
        end
    end

    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.match_found   = r_out_found;
    assign o_out_ch.match_address = r_out_addr;

`ifndef SYNTH
    // not-found results always carry a zero address
    a_miss_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && !o_out_ch.match_found) |-> (o_out_ch.match_address == '0))
        else $error("not-found result with nonzero address");

    // input stalls only when both stages are full and the output is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ch.ready |-> (w_stage.valid && r_out_valid && !o_out_ch.ready))
        else $error("input stalled without backpressure");

    // the last byte of a scan rearms the match flag
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_stage.last) |=> !r_reported)
        else $error("match flag survived end of scan");

    // a scan that already reported never reports again
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_reported) |=> !(r_out_valid && !$stable(r_out_addr)
            && r_out_found && !$past(r_out_valid && !o_out_ch.ready)))
        else $error("second result in one scan");
`endif

endmodule
